/* rtl/core/tec_pkg.sv */
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types, codes and the fixed escape token table of the text escape
// codec.
// ----------------------------------------------------------------------------
package tec_pkg;

  // direction register codes; any other value behaves as pass through
  localparam logic [1:0] DIR_ENCODE = 2'd0;
  localparam logic [1:0] DIR_DECODE = 2'd1;
  localparam logic [1:0] DIR_PASS   = 2'd2;

  // configuration register indexes
  localparam int unsigned REG_DIRECTION = 0;

  // configuration port geometry
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // command queue depth between front and back
  localparam int unsigned CMD_DEPTH_DEF = 2;

  // maximum bytes one input item expands to
  localparam int unsigned MAX_OUT = 4;
  // maximum held token prefix bytes
  localparam int unsigned MAX_HELD = 3;

  localparam int unsigned NUM_TOK = 9;
  localparam logic [7:0]  HASH    = 8'h23;

  // token text, first byte first; three byte tokens pad with zero
  localparam logic [7:0] TOK_TEXT [NUM_TOK][4] = '{
    '{8'h23, 8'h61, 8'h6d, 8'h70},  // #amp
    '{8'h23, 8'h65, 8'h71, 8'h00},  // #eq
    '{8'h23, 8'h6b, 8'h72, 8'h74},  // #krt
    '{8'h23, 8'h6b, 8'h6c, 8'h74},  // #klt
    '{8'h23, 8'h74, 8'h62, 8'h00},  // #tb
    '{8'h23, 8'h73, 8'h70, 8'h00},  // #sp
    '{8'h23, 8'h73, 8'h6b, 8'h00},  // #sk
    '{8'h23, 8'h72, 8'h74, 8'h00},  // #rt
    '{8'h23, 8'h6c, 8'h74, 8'h00}   // #lt
  };

  localparam logic [2:0] TOK_LEN [NUM_TOK] = '{
    3'd4, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  // plain character for each token: # = > < TAB space ; ] [
  localparam logic [7:0] TOK_PLAIN [NUM_TOK] = '{
    8'h23, 8'h3d, 8'h3e, 8'h3c, 8'h09, 8'h20, 8'h3b, 8'h5d, 8'h5b
  };

  // one converted request: up to four bytes sent in order, slot 0 first
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              nbytes;  // 1..4
    logic                    last;    // final byte ends the string
  } cmd_t;

endpackage

/* rtl/core/tec_front.sv */
// ----------------------------------------------------------------------------
// tec_front
// Accepts input bytes, classifies them against the token table and turns
// each into a command of up to four output bytes. Holds the decode prefix.
// ----------------------------------------------------------------------------
module tec_front
  import tec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] dir,
  input  logic       cfg_clr,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       cmd_wr,
  output cmd_t       cmd
);

  logic [7:0] pend_r [MAX_HELD];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       acc;

  // decode match signals
  logic [2:0]     len;
  logic [7:0]     cand [MAX_OUT];
  logic           full_hit;
  logic           pre_hit;
  logic [7:0]     full_plain;
  logic           enc_hit;
  logic [MAX_OUT-1:0][7:0] enc_bytes;
  logic [2:0]     enc_len;
  logic           emit_b;

  assign acc = push && !q_full;
  assign len = {1'b0, cnt_r} + 3'd1;

  // candidate string: held bytes followed by the new byte
  always_comb begin
    for (int i = 0; i < MAX_OUT; i++) begin
      cand[i] = (i < int'(cnt_r)) ? pend_r[i[1:0] % 2'd3] : in_byte;
    end
  end

  // compare the candidate against every token
  always_comb begin
    logic m;
    full_hit   = 1'b0;
    pre_hit    = 1'b0;
    full_plain = 8'h00;
    for (int t = 0; t < NUM_TOK; t++) begin
      m = 1'b1;
      for (int k = 0; k < MAX_OUT; k++) begin
        if ((k < int'(len)) && (TOK_TEXT[t][k] != cand[k])) begin
          m = 1'b0;
        end
      end
      if (m && (TOK_LEN[t] == len)) begin
        full_hit   = 1'b1;
        full_plain = TOK_PLAIN[t];
      end
      if (m && (TOK_LEN[t] > len)) begin
        pre_hit = 1'b1;
      end
    end
  end

  // encode lookup on the plain character
  always_comb begin
    enc_hit   = 1'b0;
    enc_bytes = {MAX_OUT{8'h00}};
    enc_len   = 3'd1;
    enc_bytes[0] = in_byte;
    for (int t = 0; t < NUM_TOK; t++) begin
      if (TOK_PLAIN[t] == in_byte) begin
        enc_hit = 1'b1;
        enc_len = TOK_LEN[t];
        for (int k = 0; k < MAX_OUT; k++) begin
          enc_bytes[k] = TOK_TEXT[t][k];
        end
      end
    end
  end

  // new byte goes out now: on a held prefix only at end of string,
  // on a failed match unless it starts a new prefix
  assign emit_b = pre_hit ? in_last : ((in_byte != HASH) || in_last);

  // build the command and the next held count
  always_comb begin
    cmd.bytes  = {MAX_OUT{8'h00}};
    cmd.nbytes = 3'd1;
    cmd.last   = in_last;
    cnt_nxt    = cnt_r;
    unique case (dir)
      DIR_ENCODE: begin
        cmd.bytes  = enc_bytes;
        cmd.nbytes = enc_hit ? enc_len : 3'd1;
      end
      DIR_DECODE: begin
        if (full_hit) begin
          cmd.bytes[0] = full_plain;
          cmd.nbytes   = 3'd1;
        end else begin
          for (int i = 0; i < MAX_OUT; i++) begin
            cmd.bytes[i] = cand[i];
          end
          // a growing prefix sends nothing until the string ends
          cmd.nbytes = (pre_hit && !in_last) ? 3'd0 :
                       ({1'b0, cnt_r} + {2'b00, emit_b});
        end
        if (in_last || full_hit) begin
          cnt_nxt = 2'd0;
        end else if (pre_hit) begin
          cnt_nxt = len[1:0];
        end else if (in_byte == HASH) begin
          cnt_nxt = 2'd1;
        end else begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        cmd.bytes[0] = in_byte;
        cmd.nbytes   = 3'd1;
      end
    endcase
  end

  // requests that produce nothing are not queued
  assign cmd_wr = acc && (cmd.nbytes != 3'd0);

  // held count
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clr) begin
      cnt_r <= 2'd0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  // held bytes, no reset needed
  always_ff @(posedge clk) begin
    if (acc && (dir == DIR_DECODE) && !in_last && !full_hit) begin
      if (pre_hit) begin
        unique case (cnt_r)
          2'd0:    pend_r[0] <= in_byte;
          2'd1:    pend_r[1] <= in_byte;
          default: pend_r[2] <= in_byte;
        endcase
      end else if (in_byte == HASH) begin
        pend_r[0] <= in_byte;
      end
    end
  end

endmodule

/* rtl/core/tec_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// tec_cmd_fifo
// Short command queue that decouples the classifying front from the
// byte serializing back.
// ----------------------------------------------------------------------------
module tec_cmd_fifo
  import tec_pkg::*;
#(
  parameter int unsigned DEPTH = CMD_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/tec_back.sv */
// ----------------------------------------------------------------------------
// tec_back
// Takes commands from the queue and sends their bytes one per cycle
// through a registered result stage, unless it holds an unpopped byte.
// ----------------------------------------------------------------------------
module tec_back
  import tec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  cmd_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;
  logic [7:0] obyte_r;
  logic       olast_r;
  logic       ovld_r;

  logic       out_rdy;
  logic       send;
  logic       fin;

  assign out_rdy = !ovld_r || pop;
  assign send    = cur_vld_r && out_rdy;
  assign fin     = ({1'b0, idx_r} + 3'd1) == cur_r.nbytes;
  assign q_rd    = q_valid && (!cur_vld_r || (send && fin));

  // current command and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (q_rd) begin
      cur_vld_r <= 1'b1;
      idx_r     <= 2'd0;
    end else if (send) begin
      cur_vld_r <= !fin;
      idx_r     <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (out_rdy) begin
      ovld_r <= send;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      obyte_r <= cur_r.bytes[idx_r];
      olast_r <= cur_r.last && fin;
    end
  end

  assign empty    = !ovld_r;
  assign out_byte = obyte_r;
  assign out_last = olast_r;

endmodule

/* rtl/core/text_escape_codec_top.sv */
// ----------------------------------------------------------------------------
// text_escape_codec_top
// Byte stream escape encoder / decoder with an APB style register port.
// ----------------------------------------------------------------------------
// Each accepted byte yields zero to four result bytes: one in pass mode,
// up to four when encoding a byte to a four byte token, and up to four
// when a failed decode match releases held bytes. Result bytes are sent
// one per clock, while the output is popped, from a registered output
// stage. The front classifies a byte in the cycle it is accepted and
// queues a command; the back serializer's single output byte per cycle is
// what sets the rate. Write the direction register only while idle; a
// write drops any held decode prefix.
// ----------------------------------------------------------------------------
module text_escape_codec_top
  import tec_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  // input queue side
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_byte,
  output logic              out_last,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [1:0] dir_r;
  logic       cfg_wr;
  logic       cmd_wr;
  cmd_t       cmd_in;
  cmd_t       cmd_out;
  logic       q_full;
  logic       q_valid;
  logic       q_rd;

  // register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_AW-1:2] == (CFG_AW-2)'(REG_DIRECTION));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCODE;
    end else if (cfg_wr) begin
      dir_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[CFG_AW-1:2] == (CFG_AW-2)'(REG_DIRECTION)) ?
                  {{(CFG_DW-2){1'b0}}, dir_r} : '0;

  assign full = q_full;

  // classify and queue
  tec_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .dir     (dir_r),
    .cfg_clr (cfg_wr),
    .push    (push),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_full  (q_full),
    .cmd_wr  (cmd_wr),
    .cmd     (cmd_in)
  );

  tec_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (cmd_out),
    .valid   (q_valid)
  );

  // serialize results
  tec_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (cmd_out),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
